// ----- rtl/tgc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg: shared types for the touch gesture classifier
// Transaction payloads, configuration bundle and gesture kind codes.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // gesture kinds as reported on the result channel
   typedef enum logic [1:0] {
      KIND_SHORT = 2'd0,
      KIND_LONG  = 2'd1,
      KIND_RIGHT = 2'd2,
      KIND_LEFT  = 2'd3
   } kind_type;

   // one panel poll
   typedef struct packed {
      logic               touched;
      logic signed [15:0] touch_x;
      logic signed [15:0] touch_y;
      logic        [31:0] now_ms;
   } req_type;

   // one classification result
   typedef struct packed {
      logic               touched_now;
      logic               event_valid;
      logic        [1:0]  event_kind;
      logic signed [15:0] event_x;
      logic signed [15:0] event_y;
   } rsp_type;

   // configuration bundle, csr block to core
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [14:0] swipe_thresh;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/tgc_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_csr: configuration registers
// Write-only register file for debounce, long-press and swipe thresholds.
// ----------------------------------------------------------------------------
module tgc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tgc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tgc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output tgc_pkg::cfg_type                          cfg_o
);

   typedef enum logic [tgc_pkg::CSR_INDEX_BITS-1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_LONG     = 2'd1,
      REG_SWIPE    = 2'd2,
      REG_UNUSED   = 2'd3
   } reg_index_type;

   tgc_pkg::cfg_type cfg_ff;
   tgc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_DEBOUNCE: cfg_in.debounce_ms   = csr_wdata;
            REG_LONG:     cfg_in.long_press_ms = csr_wdata;
            REG_SWIPE:    cfg_in.swipe_thresh  = csr_wdata[14:0];
            default:      ; // writes past the map are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= 16'd50;
         cfg_ff.long_press_ms <= 16'd1000;
         cfg_ff.swipe_thresh  <= 15'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/tgc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_core: debounce and gesture state
// Holds the press state and classifies one poll per step.
// ----------------------------------------------------------------------------
module tgc_core #(
   parameter int TIME_BITS  = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_i,
   input  tgc_pkg::req_type  poll_i,
   input  tgc_pkg::cfg_type  cfg_i,
   output tgc_pkg::rsp_type  rsp_o
);

   localparam int DX_BITS  = COORD_BITS + 1;
   localparam int CMP_BITS = (DX_BITS > 15) ? DX_BITS : 15;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_INPROG = 3'd2,
      PH_LINGER = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      PK_NONE  = 3'd0,
      PK_SHORT = 3'd1,
      PK_LONG  = 3'd2,
      PK_RIGHT = 3'd3,
      PK_LEFT  = 3'd4
   } pending_type;

   logic                         prev_raw_ff, prev_raw_in;
   logic                         stable_ff, stable_in;
   logic [TIME_BITS-1:0]         change_time_ff, change_time_in;
   phase_type                    phase_ff, phase_in, phase_mid;
   pending_type                  pending_ff, pending_in;
   logic signed [COORD_BITS-1:0] press_x_ff, press_x_in;
   logic signed [COORD_BITS-1:0] press_y_ff, press_y_in;

   logic                         raw;
   logic signed [COORD_BITS-1:0] cx, cy;
   logic [TIME_BITS-1:0]         now;
   logic [TIME_BITS-1:0]         elapsed;
   logic                         settled, held;
   logic signed [DX_BITS-1:0]    dx;
   logic [DX_BITS-1:0]           adx;
   logic                         swipe_hit;
   logic                         fire;
   tgc_pkg::kind_type            kind;
   logic signed [COORD_BITS-1:0] ex, ey;

   assign raw = poll_i.touched;
   assign cx  = poll_i.touch_x[COORD_BITS-1:0];
   assign cy  = poll_i.touch_y[COORD_BITS-1:0];
   assign now = TIME_BITS'(poll_i.now_ms);

   // a raw change restarts the timer, so elapsed is zero on that poll
   assign change_time_in = (raw != prev_raw_ff) ? now : change_time_ff;
   assign elapsed        = (raw != prev_raw_ff) ? '0 : (now - change_time_ff);
   assign settled        = elapsed > TIME_BITS'(cfg_i.debounce_ms);
   assign held           = elapsed > TIME_BITS'(cfg_i.long_press_ms);
   assign prev_raw_in    = raw;

   // horizontal move from the latched point, exact
   assign dx        = DX_BITS'(cx) - DX_BITS'(press_x_ff);
   assign adx       = dx[DX_BITS-1] ? DX_BITS'(-dx) : DX_BITS'(dx);
   assign swipe_hit = CMP_BITS'(adx) > CMP_BITS'(cfg_i.swipe_thresh);

   always_comb begin
      stable_in  = stable_ff;
      phase_mid  = phase_ff;
      pending_in = pending_ff;
      press_x_in = press_x_ff;
      press_y_in = press_y_ff;
      fire       = 1'b0;
      kind       = tgc_pkg::KIND_SHORT;
      ex         = '0;
      ey         = '0;

      // debounced edge of the stable state
      if (settled && (raw != stable_ff)) begin
         stable_in = raw;
         if (raw) begin
            pending_in = PK_NONE;
            phase_mid  = PH_START;
            press_x_in = cx;
            press_y_in = cy;
         end else begin
            phase_mid = PH_END;
         end
      end

      phase_in = phase_mid;
      unique case (phase_mid)
         PH_START: begin
            phase_in   = PH_INPROG;
            pending_in = PK_SHORT;
         end
         PH_INPROG: begin
            if (swipe_hit) begin
               pending_in = dx[DX_BITS-1] ? PK_LEFT : PK_RIGHT;
               kind       = dx[DX_BITS-1] ? tgc_pkg::KIND_LEFT : tgc_pkg::KIND_RIGHT;
               fire       = 1'b1;
               ex         = press_x_ff;
               ey         = press_y_ff;
               phase_in   = PH_LINGER;
            end else if ((pending_ff == PK_SHORT) && held) begin
               pending_in = PK_LONG;
               kind       = tgc_pkg::KIND_LONG;
               fire       = 1'b1;
               ex         = press_x_ff;
               ey         = press_y_ff;
               phase_in   = PH_LINGER;
            end
         end
         PH_END: begin
            if (pending_ff == PK_SHORT) begin
               fire = 1'b1;
               ex   = press_x_ff;
               ey   = press_y_ff;
            end
            phase_in   = PH_IDLE;
            press_x_in = '0;
            press_y_in = '0;
         end
         default: ; // idle, linger and unused codes hold
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         phase_ff       <= PH_IDLE;
         pending_ff     <= PK_NONE;
         press_x_ff     <= '0;
         press_y_ff     <= '0;
      end else if (step_i) begin
         prev_raw_ff    <= prev_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         press_x_ff     <= press_x_in;
         press_y_ff     <= press_y_in;
      end
   end

   always_comb begin
      rsp_o.touched_now = raw;
      rsp_o.event_valid = fire;
      rsp_o.event_kind  = kind;
      rsp_o.event_x     = 16'(ex);
      rsp_o.event_y     = 16'(ey);
   end

   // start phase is consumed within the step that latches the press
   a_no_start_stored: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_START)
      else $error("start phase left in state register");

   // a gesture ends the press: linger after swipe/long, idle after short
   a_fire_next_phase: assert property (@(posedge clock) disable iff (reset)
      step_i && fire |=> (phase_ff == PH_LINGER) || (phase_ff == PH_IDLE))
      else $error("unexpected phase after gesture");

   // idle means no latched point
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (press_x_ff == '0) && (press_y_ff == '0))
      else $error("latched point not cleared in idle");

endmodule
`default_nettype wire

// ----- rtl/touch_gesture_classifier.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_classifier: polled touch gesture detector
// Debounces the raw touch flag and classifies presses as short, long or
// horizontal swipe, one result transaction per poll.
// ----------------------------------------------------------------------------
// Every poll transaction taken on req_ yields exactly one result transaction
// on rsp_, in order. A poll is held in the input register, is classified
// by the core in the cycle it moves into the result register, and appears
// on rsp_ from the result register. One poll per cycle is sustained while
// rsp_stall stays low: the core's whole state update (debounce timer
// compare, swipe compare, long-press compare) is done in that step. With
// rsp_stall high the result register holds and the input register can still
// take one more poll before req_stall rises. Thresholds are written on the
// csr_ port (0 debounce_ms, 1 long_press_ms, 2 swipe threshold in pixels)
// while no poll is in flight. Time differences wrap modulo 2^TIME_BITS;
// coordinates use the low COORD_BITS of touch_x/touch_y, sign extended.
// ----------------------------------------------------------------------------
module touch_gesture_classifier #(
   parameter int TIME_BITS  = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // poll channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  tgc_pkg::req_type                         req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output tgc_pkg::rsp_type                         rsp_data,
   // configuration writes
   input  wire logic                                csr_we,
   input  wire logic [tgc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tgc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   tgc_pkg::cfg_type cfg;

   // input register
   tgc_pkg::req_type in_ff, in_in;
   logic             in_v_ff, in_v_in;
   // result register
   tgc_pkg::rsp_type out_ff, out_in;
   logic             out_v_ff, out_v_in;

   logic advance;   // poll moves from input register into result register
   logic load_in;   // new poll transaction taken

   tgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   tgc_core #(
      .TIME_BITS  (TIME_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_i (advance),
      .poll_i (in_ff),
      .cfg_i  (cfg),
      .rsp_o  (out_in)
   );

   // result register frees up when empty or being taken this cycle
   assign advance   = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   assign in_in    = load_in ? req_data : in_ff;
   assign in_v_in  = load_in || (in_v_ff && !advance);
   assign out_v_in = advance || (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // a held poll keeps its slot and contents until it advances
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !advance |=> in_v_ff && $stable(in_ff))
      else $error("input register lost a waiting poll");

   // back-pressure only when both registers are occupied and the result is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_v_ff && out_v_ff && rsp_stall)
      else $error("req_stall without a full pipeline");

   // an advanced poll always lands in the result register
   a_advance_src: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_v_ff)
      else $error("advanced poll did not reach result register");

endmodule
`default_nettype wire

// ----- bench/touch_gesture_classifier_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb: self-checking bench for the gesture classifier
// Drives panel polls with random pacing on both channels, predicts every result
// transaction with a behavioral model of the debounce and gesture logic, and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb;

   // settling margin after the block drains, before a threshold write
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int HOLD_CYCLES   = 60;

   // threshold register indexes on the csr_ port
   typedef enum logic [tgc_pkg::CSR_INDEX_BITS-1:0] {
      REG_DEBOUNCE_MS   = 2'd0,
      REG_LONG_PRESS_MS = 2'd1,
      REG_SWIPE_THRESH  = 2'd2
   } csr_reg_type;

   // press tracking phases of the predictor; unused codes hold
   typedef enum logic [2:0] {
      GP_IDLE    = 3'd0,
      GP_START   = 3'd1,
      GP_PRESSED = 3'd2,
      GP_LINGER  = 3'd3,
      GP_RELEASE = 3'd4
   } press_phase_type;

   // gesture armed or already fired for the current press
   typedef enum logic [2:0] {
      ARM_NONE  = 3'd0,
      ARM_SHORT = 3'd1,
      ARM_LONG  = 3'd2,
      ARM_RIGHT = 3'd3,
      ARM_LEFT  = 3'd4
   } armed_kind_type;

   // gesture shapes produced by the traffic generator
   typedef enum int {
      SHAPE_SHORT,
      SHAPE_LONG,
      SHAPE_SWIPE,
      SHAPE_SWIPE_ON_RELEASE
   } shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   tgc_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tgc_pkg::rsp_type  rsp_data;
   logic                               csr_we    = 1'b0;
   logic [tgc_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [tgc_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   touch_gesture_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Gesture predictor state, starting at the block's reset values
   // ---------------------------------------------------------------------
   logic [15:0]         thr_debounce = 16'd50;
   logic [15:0]         thr_long     = 16'd1000;
   logic [14:0]         thr_swipe    = 15'd20;

   logic                last_raw     = 1'b0;
   logic                debounced    = 1'b0;
   logic [31:0]         change_stamp = '0;
   press_phase_type     press_phase  = GP_IDLE;
   armed_kind_type      armed_kind   = ARM_NONE;
   logic signed [15:0]  latch_x      = '0;
   logic signed [15:0]  latch_y      = '0;

   tgc_pkg::rsp_type expected_results[$];
   int          mismatch_count = 0;
   int          polls_sent     = 0;
   logic [31:0] wall_ms        = '0;   // panel clock seen by the generator
   bit          random_pacing  = 1'b1; // both sides idle at random when set
   int          hold_request   = 0;    // long receiver hold, in cycles

   // Works out the result of one poll and advances the press state.
   function automatic tgc_pkg::rsp_type classify_poll(input tgc_pkg::req_type p);
      tgc_pkg::rsp_type r;
      logic [31:0]      held;
      int               dx;
      int               adx;
      r             = '0;
      r.touched_now = p.touched;
      // any raw edge restarts the debounce window
      if (p.touched != last_raw)
         change_stamp = p.now_ms;
      held = p.now_ms - change_stamp;   // wraps modulo 2^32
      if (held > 32'(thr_debounce) && p.touched != debounced) begin
         debounced = p.touched;
         if (p.touched) begin
            armed_kind  = ARM_NONE;
            press_phase = GP_START;
            latch_x     = p.touch_x;
            latch_y     = p.touch_y;
         end else begin
            press_phase = GP_RELEASE;
         end
      end
      case (press_phase)
         GP_START: begin
            // start poll only arms a short press
            press_phase = GP_PRESSED;
            armed_kind  = ARM_SHORT;
         end
         GP_PRESSED: begin
            // current x is used even if the raw flag already dropped
            dx  = int'(p.touch_x) - int'(latch_x);
            adx = (dx < 0) ? -dx : dx;
            if (adx > int'(thr_swipe)) begin
               armed_kind    = (dx > 0) ? ARM_RIGHT : ARM_LEFT;
               r.event_valid = 1'b1;
               r.event_kind  = (dx > 0) ? tgc_pkg::KIND_RIGHT : tgc_pkg::KIND_LEFT;
               r.event_x     = latch_x;
               r.event_y     = latch_y;
               press_phase   = GP_LINGER;
            end else if (armed_kind == ARM_SHORT && held > 32'(thr_long)) begin
               armed_kind    = ARM_LONG;
               r.event_valid = 1'b1;
               r.event_kind  = tgc_pkg::KIND_LONG;
               r.event_x     = latch_x;
               r.event_y     = latch_y;
               press_phase   = GP_LINGER;
            end
         end
         GP_RELEASE: begin
            if (armed_kind == ARM_SHORT) begin
               r.event_valid = 1'b1;
               r.event_kind  = tgc_pkg::KIND_SHORT;
               r.event_x     = latch_x;
               r.event_y     = latch_y;
            end
            press_phase = GP_IDLE;
            latch_x     = '0;
            latch_y     = '0;
         end
         default: ;   // idle, linger and unused codes hold
      endcase
      last_raw = p.touched;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, watchdog
   // ---------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycles_run;
      cycles_run = 0;
      forever begin
         @(posedge clock);
         cycles_run++;
         if (cycles_run > CYCLE_LIMIT) begin
            $display("touch_gesture_classifier verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------------
   // Draws a stall for every result transaction; a pending hold request
   // takes precedence and keeps the channel blocked for that many cycles.
   initial begin : result_receiver
      int wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
            wait_cycles  = 0;
         end else begin
            wait_cycles = random_pacing ? $urandom_range(0, 5) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin : result_checker
      tgc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no poll outstanding");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.touched_now !== want.touched_now) begin
               $error("touched_now: expected %0d, got %0d",
                      want.touched_now, rsp_data.touched_now);
               mismatch_count++;
            end
            if (rsp_data.event_valid !== want.event_valid) begin
               $error("event_valid: expected %0d, got %0d",
                      want.event_valid, rsp_data.event_valid);
               mismatch_count++;
            end
            if (rsp_data.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, got %0d",
                      want.event_kind, rsp_data.event_kind);
               mismatch_count++;
            end
            if (rsp_data.event_x !== want.event_x) begin
               $error("event_x: expected %0d, got %0d",
                      want.event_x, rsp_data.event_x);
               mismatch_count++;
            end
            if (rsp_data.event_y !== want.event_y) begin
               $error("event_y: expected %0d, got %0d",
                      want.event_y, rsp_data.event_y);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Poll side
   // ---------------------------------------------------------------------
   // One poll transaction. Valid stays high on return so back-to-back
   // polls need no bubble; whoever stops sending lowers it.
   task automatic send_poll(input tgc_pkg::req_type p);
      int gap;
      gap = random_pacing ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_results.push_back(classify_poll(p));
      polls_sent++;
   endtask

   // Poll at dt_ms after the previous one.
   task automatic poll(input bit touched, input int x, input int y,
                       input int unsigned dt_ms);
      tgc_pkg::req_type p;
      wall_ms   = wall_ms + dt_ms;
      p.touched = touched;
      p.touch_x = 16'(x);
      p.touch_y = 16'(y);
      p.now_ms  = wall_ms;
      send_poll(p);
   endtask

   // Drop valid, let every outstanding result drain, then let the pipe settle.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input csr_reg_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_DEBOUNCE_MS:   thr_debounce = value;
         REG_LONG_PRESS_MS: thr_long     = value;
         REG_SWIPE_THRESH:  thr_swipe    = value[14:0];
         default: ;
      endcase
   endtask

   // Thresholds only change with nothing in flight.
   task automatic apply_thresholds(input logic [15:0] debounce,
                                   input logic [15:0] long_press,
                                   input logic [14:0] swipe);
      wait_for_quiet();
      write_threshold(REG_DEBOUNCE_MS, debounce);
      write_threshold(REG_LONG_PRESS_MS, long_press);
      write_threshold(REG_SWIPE_THRESH, {1'b0, swipe});
   endtask

   function automatic int clamp_coord(input int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   // x within the swipe threshold of x0, so no swipe can fire
   function automatic int near_x(input int x0);
      return clamp_coord(x0 + int'($urandom_range(0, 2 * int'(thr_swipe)))
                            - int'(thr_swipe));
   endfunction

   // Mostly well-formed presses with random content, sized from the current
   // thresholds so they get past debounce; the rest is noise and presses
   // that bounce or break off before they settle.
   task automatic run_gesture_traffic(input int n_polls);
      int        stop_at;
      int        x0, y0, x1, mag;
      bit        to_right;
      shape_type shape;
      int unsigned pick;
      stop_at = polls_sent + n_polls;
      while (polls_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         x0   = $urandom_range(0, 65535) - 32768;
         y0   = $urandom_range(0, 65535) - 32768;
         if (pick == 0) begin
            // raw noise: every field random, time jumps anywhere
            wall_ms = $urandom;
            poll(1'($urandom_range(0, 1)), x0, y0, 0);
         end else if (pick == 1) begin
            // contact chatter with random gaps of 0 to thr_debounce + 2 ms
            repeat ($urandom_range(1, 4))
               poll(1'($urandom_range(0, 1)), near_x(x0), y0,
                    $urandom_range(0, 32'(thr_debounce) + 2));
         end else begin
            shape = shape_type'($urandom_range(0, 3));
            x1    = x0;
            if (shape == SHAPE_SWIPE || shape == SHAPE_SWIPE_ON_RELEASE) begin
               mag      = int'(thr_swipe) + 1 + $urandom_range(0, 40);
               to_right = 1'($urandom_range(0, 1));
               if (to_right) begin
                  if (x0 + mag > 32767)
                     x0 = 32767 - mag;
                  x1 = x0 + mag;
               end else begin
                  if (x0 - mag < -32768)
                     x0 = -32768 + mag;
                  x1 = x0 - mag;
               end
            end
            // touch-down, sometimes with a bounce, then the debounced press
            poll(1'b1, x0, y0, $urandom_range(1, 4));
            if ($urandom_range(0, 3) == 0) begin
               poll(1'b0, x0, y0, 1);
               poll(1'b1, x0, y0, 1);
            end
            poll(1'b1, x0, y0, 32'(thr_debounce) + 1 + $urandom_range(0, 3));
            case (shape)
               SHAPE_SHORT:
                  repeat ($urandom_range(0, 3)) poll(1'b1, near_x(x0), y0, 1);
               SHAPE_LONG:
                  poll(1'b1, near_x(x0), y0, 32'(thr_long) + 1 + $urandom_range(0, 3));
               SHAPE_SWIPE:
                  poll(1'b1, x1, y0, $urandom_range(1, 3));
               default:
                  poll(1'b0, x1, y0, 1);   // moved on the lift-off poll
            endcase
            // lingering polls after a fired gesture
            if (shape != SHAPE_SHORT)
               repeat ($urandom_range(0, 2)) poll(1'b1, near_x(x1), y0, 1);
            // lift-off, debounced unless the press is broken off
            poll(1'b0, x1, y0, 1);
            if ($urandom_range(0, 7) != 0)
               poll(1'b0, x1, y0, 32'(thr_debounce) + 1 + $urandom_range(0, 3));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Hand-built presses with tight thresholds: coordinate extremes, each
   // gesture kind, exact threshold, swipe on the lift-off poll, swipe
   // winning over long, silent release after swipe and long. The panel
   // clock starts just below the wrap point so the presses straddle it.
   task automatic test_directed_gestures();
      apply_thresholds(16'd2, 16'd10, 15'd5);
      wall_ms = 32'hFFFF_FFF0;
      // extreme latch point, swipe right over the full 16-bit span
      poll(1'b1, -32768, 32767, 1);
      poll(1'b1, -32768, 32767, 3);
      poll(1'b1, 32767, -32768, 1);
      poll(1'b1, 0, 0, 20);            // lingering, no long
      poll(1'b0, 0, 0, 1);
      poll(1'b0, 0, 0, 3);             // release after swipe stays silent
      // short press, move exactly at the threshold does not count
      poll(1'b1, 100, -100, 1);
      poll(1'b1, 100, -100, 3);
      poll(1'b1, 105, -100, 1);
      poll(1'b0, 100, -100, 1);
      poll(1'b0, 100, -100, 3);        // short, then point cleared
      // swipe left seen on the poll where the raw flag drops
      poll(1'b1, 50, 60, 1);
      poll(1'b1, 50, 60, 3);
      poll(1'b0, 44, 60, 1);
      poll(1'b0, 0, 0, 3);
      // long press with small drift
      poll(1'b1, 7, 7, 1);
      poll(1'b1, 7, 7, 3);
      poll(1'b1, 9, 7, 20);
      poll(1'b0, 9, 7, 1);
      poll(1'b0, 9, 7, 3);             // release after long stays silent
      // swipe and long both due: swipe wins
      poll(1'b1, -7, 8, 1);
      poll(1'b1, -7, 8, 3);
      poll(1'b1, 20, 8, 20);
      poll(1'b0, 20, 8, 1);
      poll(1'b0, 20, 8, 3);
   endtask

   task automatic test_default_thresholds();
      apply_thresholds(16'd50, 16'd1000, 15'd20);
      run_gesture_traffic(110);
   endtask

   // all-zero thresholds, then all at maximum without random idling
   task automatic test_threshold_extremes();
      apply_thresholds(16'd0, 16'd0, 15'd0);
      run_gesture_traffic(60);
      random_pacing = 1'b0;
      apply_thresholds(16'hFFFF, 16'hFFFF, 15'h7FFF);
      run_gesture_traffic(60);
      random_pacing = 1'b1;
   endtask

   task automatic test_random_thresholds();
      repeat (3) begin
         apply_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          15'($urandom_range(0, 32767)));
         run_gesture_traffic(60);
      end
   endtask

   // Receiver blocks for a long stretch while polls keep coming, so both
   // pipeline registers fill and req_stall must rise.
   task automatic test_back_pressure();
      apply_thresholds(16'd3, 16'd40, 15'd10);
      random_pacing = 1'b0;
      hold_request  = HOLD_CYCLES;
      run_gesture_traffic(30);
      wait_for_quiet();
      random_pacing = 1'b1;
   endtask

   initial begin : test_sequence
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_gestures();
      test_default_thresholds();
      test_threshold_extremes();
      test_random_thresholds();
      test_back_pressure();

      wait_for_quiet();
      if (mismatch_count == 0)
         $display("touch_gesture_classifier verification clean");
      else
         $display("touch_gesture_classifier verification failed");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/tgc_pkg.sv
rtl/tgc_csr.sv
rtl/tgc_core.sv
rtl/touch_gesture_classifier.sv
bench/touch_gesture_classifier_tb.sv
